FILE: rtl/core/mlds_pkg.sv
// Shared types, constants and lookup functions for the multiplexed LED display scanner.
package mlds_pkg;

   localparam int NUM_DIGITS_DEFAULT       = 6;
   localparam int NUM_BANKS_DEFAULT        = 4;
   localparam int NUM_STATUS_STEPS_DEFAULT = 8;

   localparam int MASK_BITS   = 20;
   localparam int STATUS_BITS = 7;
   localparam int COLUMNS     = 5;
   localparam int NUMBER_W    = 20;
   localparam int RECIP_W     = 21;
   localparam int PRODUCT_W   = NUMBER_W + RECIP_W;

   localparam logic [NUMBER_W-1:0] NUMBER_MAX = 20'd999999;

   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_SET_STATUS = 3'd1;
   localparam logic [2:0] CMD_SET_GREEN  = 3'd2;
   localparam logic [2:0] CMD_SET_RED    = 3'd3;
   localparam logic [2:0] CMD_SET_NUMBER = 3'd4;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] status_pins;
      logic [3:0] bank_select;
      logic [4:0] red_columns;
      logic [4:0] green_columns;
      logic [5:0] digit_enable_n;
      logic [7:0] segment_bits;
   } rsp_type;

   // Segment pattern of a decimal digit, before inversion.
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pattern;
      case (digit)
         4'd0:    pattern = 8'b11110011;
         4'd1:    pattern = 8'b01100000;
         4'd2:    pattern = 8'b11010101;
         4'd3:    pattern = 8'b11110100;
         4'd4:    pattern = 8'b01100110;
         4'd5:    pattern = 8'b10110110;
         4'd6:    pattern = 8'b10110111;
         4'd7:    pattern = 8'b11100000;
         4'd8:    pattern = 8'b11110111;
         4'd9:    pattern = 8'b11100110;
         default: pattern = 8'b00000000;
      endcase
      return pattern;
   endfunction

   // Status line code for each encoder step; the last step lights nothing.
   function automatic logic [2:0] status_code(input logic [2:0] step);
      logic [2:0] code;
      case (step)
         3'd0:    code = 3'd5;
         3'd1:    code = 3'd1;
         3'd2:    code = 3'd7;
         3'd3:    code = 3'd2;
         3'd4:    code = 3'd3;
         3'd5:    code = 3'd4;
         3'd6:    code = 3'd6;
         default: code = 3'd0;
      endcase
      return code;
   endfunction

   // Reciprocal of 10**pos, rounded up, exact for any 20-bit dividend
   // when the product is shifted right by shift_of(pos).
   function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] pos);
      logic [RECIP_W-1:0] recip;
      case (pos)
         3'd0:    recip = 21'd1048576;
         3'd1:    recip = 21'd1677722;
         3'd2:    recip = 21'd1342178;
         3'd3:    recip = 21'd1073742;
         3'd4:    recip = 21'd1717987;
         3'd5:    recip = 21'd1374390;
         3'd6:    recip = 21'd1099512;
         default: recip = 21'd1759219;
      endcase
      return recip;
   endfunction

   function automatic logic [5:0] shift_of(input logic [2:0] pos);
      logic [5:0] shift;
      case (pos)
         3'd0:    shift = 6'd20;
         3'd1:    shift = 6'd24;
         3'd2:    shift = 6'd27;
         3'd3:    shift = 6'd30;
         3'd4:    shift = 6'd34;
         3'd5:    shift = 6'd37;
         3'd6:    shift = 6'd40;
         default: shift = 6'd44;
      endcase
      return shift;
   endfunction

endpackage

FILE: rtl/core/multiplexed_led_display_scanner_unit.sv
// Top level of the multiplexed LED display scanner: status encoder, LED matrix and digit scan.
// A request is registered in stage one when accepted, its quotient in stage two, and its
// response in the response register, from which it can be taken.
// Throughput: one request per cycle unless a stalled response backs up the pipeline; the
// digit divide by a power of ten and the final divide by ten each use one reciprocal
// multiplier, in two separate pipeline stages. Reset: synchronous and active high; it
// clears all display values, scan counters and pipeline valid bits.
module multiplexed_led_display_scanner_unit #(
   parameter int NUM_DIGITS       = mlds_pkg::NUM_DIGITS_DEFAULT,
   parameter int NUM_BANKS        = mlds_pkg::NUM_BANKS_DEFAULT,
   parameter int NUM_STATUS_STEPS = mlds_pkg::NUM_STATUS_STEPS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mlds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mlds_pkg::rsp_type rsp_data
);

   localparam int POS_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
   localparam int STEP_W = $clog2(NUM_STATUS_STEPS);

   // Display values and scan counters. These are architectural state and
   // change only when a request is accepted.
   logic [mlds_pkg::STATUS_BITS-1:0] status_mask_ff, status_mask_in;
   logic [mlds_pkg::MASK_BITS-1:0]   red_bits_ff, red_bits_in;
   logic [mlds_pkg::MASK_BITS-1:0]   green_bits_ff, green_bits_in;
   logic [mlds_pkg::NUMBER_W-1:0]    number_ff, number_in;
   logic [POS_W-1:0]                 pos_ff, pos_in;
   logic [BANK_W-1:0]                bank_ff, bank_in;
   logic [STEP_W-1:0]                step_ff, step_in;

   // Pipeline: stage one holds everything but the segment byte plus the
   // number and digit position; stage two holds the number divided by the
   // power of ten; the response register holds the finished response.
   logic                          s1_valid_ff, s1_valid_in;
   mlds_pkg::rsp_type             s1_rsp_ff, s1_rsp_in;
   logic [mlds_pkg::NUMBER_W-1:0] s1_num_ff, s1_num_in;
   logic [2:0]                    s1_pos_ff, s1_pos_in;

   logic                          s2_valid_ff, s2_valid_in;
   mlds_pkg::rsp_type             s2_rsp_ff, s2_rsp_in;
   logic [mlds_pkg::NUMBER_W-1:0] s2_quot_ff, s2_quot_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   mlds_pkg::rsp_type             rsp_ff, rsp_in;

   logic en_out, en2, en1, accept;

   // Each stage moves when the one after it is empty or moving, so bubbles
   // close up and a request can enter while a response waits downstream.
   assign en_out = !rsp_valid_ff || rsp_ready;
   assign en2    = !s2_valid_ff || en_out;
   assign en1    = !s1_valid_ff || en2;
   assign accept = req_valid && en1;

   assign req_ready = en1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Display value updates and scan counter advance.
   always_comb begin
      status_mask_in = status_mask_ff;
      red_bits_in    = red_bits_ff;
      green_bits_in  = green_bits_ff;
      number_in      = number_ff;
      pos_in         = pos_ff;
      bank_in        = bank_ff;
      step_in        = step_ff;
      if (accept) begin
         case (req_data.cmd)
            mlds_pkg::CMD_SET_STATUS: begin
               status_mask_in = req_data.value[mlds_pkg::STATUS_BITS-1:0];
            end
            mlds_pkg::CMD_SET_GREEN: begin
               green_bits_in = req_data.value[mlds_pkg::MASK_BITS-1:0];
            end
            mlds_pkg::CMD_SET_RED: begin
               red_bits_in = req_data.value[mlds_pkg::MASK_BITS-1:0];
            end
            mlds_pkg::CMD_SET_NUMBER: begin
               // Numbers beyond six digits are pinned to the largest one shown.
               if (req_data.value > 32'(mlds_pkg::NUMBER_MAX)) begin
                  number_in = mlds_pkg::NUMBER_MAX;
               end else begin
                  number_in = req_data.value[mlds_pkg::NUMBER_W-1:0];
               end
            end
            default: begin
               // A plain tick or an unused command stores nothing.
            end
         endcase
         pos_in  = (pos_ff == POS_W'(NUM_DIGITS - 1)) ? '0 : pos_ff + POS_W'(1);
         bank_in = (bank_ff == BANK_W'(NUM_BANKS - 1)) ? '0 : bank_ff + BANK_W'(1);
         step_in = (step_ff == STEP_W'(NUM_STATUS_STEPS - 1)) ? '0 : step_ff + STEP_W'(1);
      end
   end

   // Stage one: status lines, bank and columns, digit enable. The status
   // encoder uses the step after advancing; the matrix and digit scan use
   // the bank and position before advancing. All use the updated values.
   always_comb begin
      logic [2:0] step_ext;
      logic [2:0] bank_ext;
      logic [2:0] pos_ext;
      logic [7:0] status_ext;
      int         idx;
      step_ext   = 3'(step_in);
      bank_ext   = 3'(bank_ff);
      pos_ext    = 3'(pos_ff);
      status_ext = {1'b0, status_mask_in};

      s1_rsp_in = '0;
      s1_rsp_in.status_pins = status_ext[step_ext] ? mlds_pkg::status_code(step_ext) : 3'd0;
      s1_rsp_in.bank_select = (bank_ext < 3'd4) ? (4'b0001 << bank_ext[1:0]) : 4'b0000;
      for (int k = 0; k < mlds_pkg::COLUMNS; k++) begin
         // Banks are wired in reverse order onto the mask bits.
         idx = NUM_BANKS - 1 - int'(bank_ff) + NUM_BANKS * k;
         if (idx < mlds_pkg::MASK_BITS) begin
            s1_rsp_in.red_columns[k]   = red_bits_in[idx[4:0]];
            s1_rsp_in.green_columns[k] = green_bits_in[idx[4:0]];
         end
      end
      s1_rsp_in.digit_enable_n = (pos_ext < 3'd6) ? ~(6'b000001 << pos_ext) : 6'b111111;

      s1_num_in   = number_in;
      s1_pos_in   = pos_ext;
      s1_valid_in = en1 ? req_valid : s1_valid_ff;
   end

   // Stage two: divide the number by ten to the digit position with an
   // exact reciprocal multiply and shift.
   always_comb begin
      logic [mlds_pkg::PRODUCT_W-1:0] prod;
      prod = mlds_pkg::PRODUCT_W'(s1_num_ff)
           * mlds_pkg::PRODUCT_W'(mlds_pkg::recip_of(s1_pos_ff));
      s2_quot_in  = mlds_pkg::NUMBER_W'(prod >> mlds_pkg::shift_of(s1_pos_ff));
      s2_rsp_in   = s1_rsp_ff;
      s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;
   end

   // Response stage: the low decimal digit of the quotient, by a divide by
   // ten through the same reciprocal method, then the inverted segment byte.
   always_comb begin
      logic [mlds_pkg::PRODUCT_W-1:0] prod10;
      logic [16:0]                    quot10;
      logic [mlds_pkg::NUMBER_W-1:0]  tens;
      logic [mlds_pkg::NUMBER_W-1:0]  rem;
      prod10 = mlds_pkg::PRODUCT_W'(s2_quot_ff)
             * mlds_pkg::PRODUCT_W'(mlds_pkg::recip_of(3'd1));
      quot10 = prod10[40:24];
      tens   = {quot10, 3'b000} + {2'b00, quot10, 1'b0};
      rem    = s2_quot_ff - tens;

      rsp_in              = s2_rsp_ff;
      rsp_in.segment_bits = ~mlds_pkg::seg_pattern(rem[3:0]);
      rsp_valid_in        = en_out ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_mask_ff <= '0;
         red_bits_ff    <= '0;
         green_bits_ff  <= '0;
         number_ff      <= '0;
         pos_ff         <= '0;
         bank_ff        <= '0;
         step_ff        <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         status_mask_ff <= status_mask_in;
         red_bits_ff    <= red_bits_in;
         green_bits_ff  <= green_bits_in;
         number_ff      <= number_in;
         pos_ff         <= pos_in;
         bank_ff        <= bank_in;
         step_ff        <= step_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers load whenever their stage moves.
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_rsp_ff <= s1_rsp_in;
         s1_num_ff <= s1_num_in;
         s1_pos_ff <= s1_pos_in;
      end
      if (en2) begin
         s2_rsp_ff  <= s2_rsp_in;
         s2_quot_ff <= s2_quot_in;
      end
      if (en_out) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: rtl/core/mlds_checker.sv
// Port-level assertions for the LED display scanner and the bind that attaches them.
module mlds_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mlds_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mlds_pkg::rsp_type rsp_data
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // At most one bank and at most one digit are driven at a time.
   a_one_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_data.bank_select))
      else $error("more than one bank selected");

   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(~rsp_data.digit_enable_n) <= 1)
      else $error("more than one digit enabled");

   // With nothing in flight the block must take a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with an empty output");

endmodule

bind multiplexed_led_display_scanner_unit mlds_checker u_mlds_checker (.*);

FILE: verif/tb_multiplexed_led_display_scanner_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multiplexed LED display scanner: directed table, random ticks.
module tb_multiplexed_led_display_scanner_unit;

   // Timing of the run. The hold-off makes the receiver refuse responses for a long
   // stretch while the sender keeps offering requests, so the pipeline fills up.
   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 8;
   localparam int RANDOM_REQUESTS = 550;
   localparam int MAX_WAIT        = 14;
   localparam int DRAIN_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_START      = 1500;
   localparam int HOLD_CYCLES     = 80;
   localparam int REPORT_LIMIT    = 10;

   // Command codes that the block does not decode; the tick still happens.
   localparam logic [2:0] CMD_SPARE_A = 3'd5;
   localparam logic [2:0] CMD_SPARE_B = 3'd6;
   localparam logic [2:0] CMD_SPARE_C = 3'd7;

   // Segment patterns of digits 9 down to 0, before inversion, eight bits per digit.
   localparam logic [79:0] GLYPHS = {8'hE6, 8'hF7, 8'hE0, 8'hB7, 8'hB6,
                                     8'h66, 8'hF4, 8'hD5, 8'h60, 8'hF3};
   // Status line codes of encoder steps 7 down to 0; step seven lights nothing.
   localparam logic [23:0] LED_CODES = {3'd0, 3'd6, 3'd4, 3'd3, 3'd2, 3'd7, 3'd1, 3'd5};

   // One row of the directed table. When typed is set, want holds the response
   // written out by hand; otherwise the predictor supplies it.
   typedef struct packed {
      mlds_pkg::req_type req;
      logic              typed;
      mlds_pkg::rsp_type want;
   } scan_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mlds_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   mlds_pkg::rsp_type rsp_data;

   // Predicted display state, mirroring what the block should hold.
   logic [mlds_pkg::STATUS_BITS-1:0] led_mask     = '0;
   logic [mlds_pkg::MASK_BITS-1:0]   red_bits     = '0;
   logic [mlds_pkg::MASK_BITS-1:0]   green_bits   = '0;
   logic [mlds_pkg::NUMBER_W-1:0]    shown_number = '0;
   logic [2:0]                       digit_pos    = '0;
   logic [1:0]                       scan_bank    = '0;
   logic [2:0]                       led_step     = '0;

   // Responses still owed by the block, oldest first.
   mlds_pkg::rsp_type pending_scans[$];
   scan_row_type      scan_rows[$];

   int cycle_count = 0;
   int hold_left   = 0;
   int fault_count = 0;
   int send_quiet  = 0;
   int recv_quiet  = 0;
   int recv_stall  = 0;

   multiplexed_led_display_scanner_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Draws how many cycles a side waits before its next request or response. Now and
   // then a quiet run starts in which the side does not wait at all.
   function automatic int pick_wait(inout int quiet_left);
      int cycles;
      cycles = 0;
      if (quiet_left != 0) begin
         quiet_left = quiet_left - 1;
      end else if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(10, 40);
      end else begin
         cycles = $urandom_range(0, MAX_WAIT);
      end
      return cycles;
   endfunction

   // Applies one scan tick to the predicted state and returns the response it causes.
   // The update is stored first, then the status encoder, the LED matrix and the digit
   // scan each take one step.
   task automatic advance_scan(input mlds_pkg::req_type r, output mlds_pkg::rsp_type o);
      logic [mlds_pkg::NUMBER_W-1:0] quotient;
      logic [3:0]                    digit;
      int                            col;
      int                            p;
      int                            k;
      o = '0;
      case (r.cmd)
         mlds_pkg::CMD_SET_STATUS: led_mask = r.value[mlds_pkg::STATUS_BITS-1:0];
         mlds_pkg::CMD_SET_GREEN:  green_bits = r.value[mlds_pkg::MASK_BITS-1:0];
         mlds_pkg::CMD_SET_RED:    red_bits = r.value[mlds_pkg::MASK_BITS-1:0];
         mlds_pkg::CMD_SET_NUMBER: begin
            // Anything wider than six decimal digits is shown as all nines.
            if (r.value > mlds_pkg::NUMBER_MAX) shown_number = mlds_pkg::NUMBER_MAX;
            else shown_number = r.value[mlds_pkg::NUMBER_W-1:0];
         end
         default: ;
      endcase

      // The step counter advances before use and wraps after eight steps.
      led_step = led_step + 3'd1;
      if (led_step < mlds_pkg::STATUS_BITS) begin
         if (led_mask[led_step]) o.status_pins = LED_CODES[led_step*3 +: 3];
      end

      // Column k of a bank shows mask bit (last bank - bank) + banks * k.
      o.bank_select = 4'b0001 << scan_bank;
      for (k = 0; k < mlds_pkg::COLUMNS; k++) begin
         col = mlds_pkg::NUM_BANKS_DEFAULT - 1 - int'(scan_bank)
             + mlds_pkg::NUM_BANKS_DEFAULT * k;
         if (col < mlds_pkg::MASK_BITS) begin
            o.red_columns[k]   = red_bits[col];
            o.green_columns[k] = green_bits[col];
         end
      end
      scan_bank = scan_bank + 2'd1;

      // Pick the decimal digit at the current position; the byte goes out inverted.
      quotient = shown_number;
      for (p = 0; p < digit_pos; p++) quotient = mlds_pkg::NUMBER_W'(quotient / 10);
      digit = 4'(quotient % 10);
      o.segment_bits   = ~GLYPHS[digit*8 +: 8];
      o.digit_enable_n = ~(6'b000001 << digit_pos);
      if (digit_pos == mlds_pkg::NUM_DIGITS_DEFAULT - 1) digit_pos = '0;
      else digit_pos = digit_pos + 3'd1;
   endtask

   task automatic add_row(input logic [2:0] cmd, input logic [31:0] value,
                          input logic typed, input mlds_pkg::rsp_type want);
      scan_row_type row;
      row.req.cmd   = cmd;
      row.req.value = value;
      row.typed     = typed;
      row.want      = want;
      scan_rows.push_back(row);
   endtask

   // Offers one request and waits for the block to take it. Valid stays high through
   // any stall. While the receiver is held off, the sender offers back to back.
   task automatic send_request(input mlds_pkg::req_type r, input logic typed,
                               input mlds_pkg::rsp_type want);
      mlds_pkg::rsp_type predicted;
      int                gap;
      gap = (hold_left != 0) ? 0 : pick_wait(send_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      advance_scan(r, predicted);
      pending_scans.push_back(typed ? want : predicted);
   endtask

   // Sender: directed table first, then random ticks, then the drain and the verdict.
   initial begin : request_driver
      mlds_pkg::req_type r;
      scan_row_type      row;
      int                pick;
      int                shape;
      int                i;

      // The first rows start from reset and set every display to its widest value, so
      // their responses can be written out directly (response fields in port order:
      // pins, bank select, red, green, digit enables, segment byte).
      add_row(mlds_pkg::CMD_TICK,       32'h0,        1'b1,
              {3'd0, 4'b0001, 5'h00, 5'h00, 6'b111110, 8'h0C});
      add_row(mlds_pkg::CMD_SET_STATUS, 32'hFFFFFFFF, 1'b1,
              {3'd7, 4'b0010, 5'h00, 5'h00, 6'b111101, 8'h0C});
      add_row(mlds_pkg::CMD_SET_RED,    32'hFFFFFFFF, 1'b1,
              {3'd2, 4'b0100, 5'h1F, 5'h00, 6'b111011, 8'h0C});
      add_row(mlds_pkg::CMD_SET_GREEN,  32'hFFFFFFFF, 1'b1,
              {3'd3, 4'b1000, 5'h1F, 5'h1F, 6'b110111, 8'h0C});
      add_row(mlds_pkg::CMD_SET_NUMBER, 32'hFFFFFFFF, 1'b1,
              {3'd4, 4'b0001, 5'h1F, 5'h1F, 6'b101111, 8'h19});
      add_row(mlds_pkg::CMD_TICK,       32'h0,        1'b1,
              {3'd6, 4'b0010, 5'h1F, 5'h1F, 6'b011111, 8'h19});
      // Step seven of the status encoder drives no line even with every mask bit set.
      add_row(mlds_pkg::CMD_TICK,       32'h0,        1'b1,
              {3'd0, 4'b0100, 5'h1F, 5'h1F, 6'b111110, 8'h19});
      // The rest is left to the predictor.
      add_row(mlds_pkg::CMD_TICK,       32'h0,        1'b0, '0);
      add_row(CMD_SPARE_A,              32'hFFFFFFFF, 1'b0, '0);
      add_row(CMD_SPARE_B,              32'h0,        1'b0, '0);
      add_row(CMD_SPARE_C,              32'h000F423F, 1'b0, '0);
      add_row(mlds_pkg::CMD_SET_NUMBER, 32'd1000000,  1'b0, '0);
      add_row(mlds_pkg::CMD_SET_NUMBER, 32'd0,        1'b0, '0);
      add_row(mlds_pkg::CMD_SET_NUMBER, 32'd123456,   1'b0, '0);
      add_row(mlds_pkg::CMD_TICK,       32'hDEADBEEF, 1'b0, '0);
      add_row(mlds_pkg::CMD_SET_STATUS, 32'hFFFFFF80, 1'b0, '0);
      add_row(mlds_pkg::CMD_SET_STATUS, 32'h00000055, 1'b0, '0);
      add_row(mlds_pkg::CMD_SET_RED,    32'hFFF00000, 1'b0, '0);
      add_row(mlds_pkg::CMD_SET_GREEN,  32'h000AAAAA, 1'b0, '0);
      add_row(mlds_pkg::CMD_SET_RED,    32'h00055555, 1'b0, '0);
      add_row(mlds_pkg::CMD_SET_NUMBER, 32'd999999,   1'b0, '0);
      add_row(mlds_pkg::CMD_SET_NUMBER, 32'd987654,   1'b0, '0);
      add_row(mlds_pkg::CMD_SET_GREEN,  32'h0,        1'b0, '0);
      add_row(mlds_pkg::CMD_TICK,       32'h0,        1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (scan_rows[n]) begin
         row = scan_rows[n];
         send_request(row.req, row.typed, row.want);
      end

      // Random ticks lean toward number updates, so that the digit scan sees many
      // values, with mask updates and undecoded commands mixed in.
      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         pick    = $urandom_range(0, 15);
         r.value = $urandom;
         if (pick < 5) r.cmd = mlds_pkg::CMD_TICK;
         else if (pick < 9) r.cmd = mlds_pkg::CMD_SET_NUMBER;
         else if (pick < 11) r.cmd = mlds_pkg::CMD_SET_STATUS;
         else if (pick == 11) r.cmd = mlds_pkg::CMD_SET_GREEN;
         else if (pick == 12) r.cmd = mlds_pkg::CMD_SET_RED;
         else if (pick == 13) r.cmd = CMD_SPARE_A;
         else if (pick == 14) r.cmd = CMD_SPARE_B;
         else r.cmd = CMD_SPARE_C;
         if (r.cmd == mlds_pkg::CMD_SET_NUMBER) begin
            shape = $urandom_range(0, 9);
            if (shape < 6) r.value = $urandom_range(0, 999999);
            else if (shape == 6) r.value = $urandom_range(999990, 1000010);
            else if (shape == 7) r.value = $urandom_range(0, 99);
         end
         send_request(r, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Wait for every owed response, then give the pipeline time to show anything extra.
      while (pending_scans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("multiplexed_led_display_scanner_unit test passed");
      end else begin
         $display("multiplexed_led_display_scanner_unit test failed");
      end
      $finish;
   end

   // Receiver: checks each accepted response against the oldest prediction and
   // may drop ready for a random number of cycles after each one.
   always @(posedge clock) begin : response_checker
      mlds_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_scans.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: response %h arrived with none expected", $time, rsp_data);
            end else begin
               want = pending_scans.pop_front();
               if (rsp_data.status_pins    !== want.status_pins    ||
                   rsp_data.bank_select    !== want.bank_select    ||
                   rsp_data.red_columns    !== want.red_columns    ||
                   rsp_data.green_columns  !== want.green_columns  ||
                   rsp_data.digit_enable_n !== want.digit_enable_n ||
                   rsp_data.segment_bits   !== want.segment_bits) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("%0t: mismatch pins %h/%h bank %h/%h red %h/%h green %h/%h en %h/%h seg %h/%h (exp/got)",
                              $time, want.status_pins, rsp_data.status_pins,
                              want.bank_select, rsp_data.bank_select,
                              want.red_columns, rsp_data.red_columns,
                              want.green_columns, rsp_data.green_columns,
                              want.digit_enable_n, rsp_data.digit_enable_n,
                              want.segment_bits, rsp_data.segment_bits);
               end
            end
         end

         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_ready) begin
            if (rsp_valid) begin
               recv_stall = pick_wait(recv_quiet);
               if (recv_stall != 0) rsp_ready <= 1'b0;
            end
         end else if (recv_stall != 0) begin
            recv_stall = recv_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long hold-off of the receiver, started once at a fixed cycle in the random part.
   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (cycle_count == HOLD_START) hold_left <= HOLD_CYCLES;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("multiplexed_led_display_scanner_unit test failed");
         $finish;
      end
   end

endmodule
